@@ hw/rtl/chroma_key_soft_blend_defines.svh @@
// Assertion macros shared by the checker of the chroma key soft blend block.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef CHROMA_KEY_SOFT_BLEND_DEFINES_SVH
`define CHROMA_KEY_SOFT_BLEND_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CKB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/ckb_pkg.sv @@
// Package of the chroma key soft blend block: widths, codes, types and the
// step functions of the square root and division pipelines. No dependencies.
`default_nettype none
package ckb_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_W        = 9;
    localparam int SQ_W         = 25;
    localparam int ROOT_W       = 13;
    localparam int SQRT_ITER    = 13;
    localparam int SQRT_PER_STG = 2;
    localparam int SQRT_STAGES  = (SQRT_ITER + SQRT_PER_STG - 1) / SQRT_PER_STG;
    localparam int Q_W          = 8;
    localparam int DIV_PER_STG  = 2;
    localparam int DIV_STAGES   = Q_W / DIV_PER_STG;
    localparam int REM_W        = ROOT_W + 1;
    localparam int ALPHA_W      = 9;
    localparam int PROD_W       = ALPHA_W + PIX_W;

    typedef enum logic [1:0] {
        REG_KEY_CR = 2'd0,
        REG_KEY_CB = 2'd1,
        REG_INNER  = 2'd2,
        REG_OUTER  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_BG   = 2'd0,
        MODE_FG   = 2'd1,
        MODE_RAMP = 2'd2
    } mode_t;

    typedef struct packed {
        logic [PIX_W-1:0] fy;
        logic [PIX_W-1:0] fcr;
        logic [PIX_W-1:0] fcb;
        logic [PIX_W-1:0] by;
        logic [PIX_W-1:0] bcr;
        logic [PIX_W-1:0] bcb;
    } pix_t;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } dv_t;

    // One iteration of the digit-by-digit square root; k counts from 0.
    function automatic sq_t sqrt_step(sq_t st, int unsigned k);
        sq_t           r;
        logic [SQ_W-1:0] b;
        logic [SQ_W:0] t;
        r = st;
        b = SQ_W'(1) << (2 * (SQRT_ITER - 1 - k));
        t = {1'b0, st.root} + {1'b0, b};
        if ({1'b0, st.v} >= t) begin
            r.v    = st.v - t[SQ_W-1:0];
            r.root = (st.root >> 1) + b;
        end else begin
            r.root = st.root >> 1;
        end
        return r;
    endfunction

    // One step of restoring division producing one quotient bit.
    function automatic dv_t div_step(dv_t st, logic [ROOT_W-1:0] den);
        dv_t          r;
        logic [REM_W:0] t;
        t = {st.rem, 1'b0};
        if (t >= {2'b00, den}) begin
            r.rem = REM_W'(t - {2'b00, den});
            r.q   = {st.q[Q_W-2:0], 1'b1};
        end else begin
            r.rem = t[REM_W-1:0];
            r.q   = {st.q[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ckb_isqrt_pipe.sv @@
// Pipelined integer square root with a pixel payload riding alongside.
// Depends on ckb_pkg.
`default_nettype none
module ckb_isqrt_pipe (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_vld,
    input  wire logic [ckb_pkg::SQ_W-1:0]   in_v,
    input  wire ckb_pkg::pix_t              in_pix,
    output logic                            out_vld,
    output logic [ckb_pkg::ROOT_W-1:0]      out_root,
    output ckb_pkg::pix_t                   out_pix
);
    import ckb_pkg::*;

    logic vld_reg [SQRT_STAGES];
    sq_t  st_reg  [SQRT_STAGES];
    pix_t pix_reg [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic vld_in;
        sq_t  st_in;
        sq_t  st_next;
        pix_t pix_in;

        if (s == 0) begin : g_first
            assign vld_in = in_vld;
            assign st_in  = '{v: in_v, root: '0};
            assign pix_in = in_pix;
        end else begin : g_rest
            assign vld_in = vld_reg[s-1];
            assign st_in  = st_reg[s-1];
            assign pix_in = pix_reg[s-1];
        end

        always_comb
        begin
            st_next = st_in;
            for (int j = 0; j < SQRT_PER_STG; j++)
            begin
                if (s * SQRT_PER_STG + j < SQRT_ITER)
                begin
                    st_next = sqrt_step(st_next, s * SQRT_PER_STG + j);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[s]  <= st_next;
                pix_reg[s] <= pix_in;
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STAGES-1];
    assign out_root = st_reg[SQRT_STAGES-1].root[ROOT_W-1:0];
    assign out_pix  = pix_reg[SQRT_STAGES-1];

endmodule
`default_nettype wire

@@ hw/rtl/chroma_key_soft_blend.sv @@
// Chroma key soft blend: one foreground and one background YCrCb pixel in,
// one blended pixel out, fully pipelined. Depends on ckb_pkg, ckb_isqrt_pipe.
//
// Usage: an input transaction (in_valid high, in_stall low at a clock edge)
// carries one foreground and one background pixel. Exactly one output
// transaction follows for each, in order, on out_valid/out_stall.
// From input transaction to out_valid the path runs through two stages for
// the chroma difference and its squared magnitude, seven for the square root
// (up to two root digits per stage), one for the threshold compare, four for the
// alpha division (two quotient bits per stage), one for the multiplies and
// one for the final sum held in the output register.
// Throughput is one pixel per clock; every stage advances together, so the
// rate is set only by the downstream side.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears every valid bit and loads the register defaults: key 0/0,
// inner threshold 100, outer threshold 115. Configuration writes are meant
// to be made while the pipeline is empty.
`default_nettype none
module chroma_key_soft_blend (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [ckb_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [ckb_pkg::PIX_W-1:0]   fg_luma,
    input  wire logic [ckb_pkg::PIX_W-1:0]   fg_cr,
    input  wire logic [ckb_pkg::PIX_W-1:0]   fg_cb,
    input  wire logic [ckb_pkg::PIX_W-1:0]   bg_luma,
    input  wire logic [ckb_pkg::PIX_W-1:0]   bg_cr,
    input  wire logic [ckb_pkg::PIX_W-1:0]   bg_cb,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [ckb_pkg::PIX_W-1:0]        out_luma,
    output logic [ckb_pkg::PIX_W-1:0]        out_cr,
    output logic [ckb_pkg::PIX_W-1:0]        out_cb
);
    import ckb_pkg::*;

    // Configuration registers.
    logic [PIX_W-1:0] key_cr_reg;
    logic [PIX_W-1:0] key_cb_reg;
    logic [CFG_W-1:0] inner_reg;
    logic [CFG_W-1:0] outer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cr_reg <= '0;
            key_cb_reg <= '0;
            inner_reg  <= CFG_W'(100);
            outer_reg  <= CFG_W'(115);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_KEY_CR: key_cr_reg <= cfg_data[PIX_W-1:0];
                REG_KEY_CB: key_cb_reg <= cfg_data[PIX_W-1:0];
                REG_INNER:  inner_reg  <= cfg_data;
                REG_OUTER:  outer_reg  <= cfg_data;
            endcase
        end
    end

    // The pipeline moves as one unless a finished result is held back.
    logic adv;
    logic out_valid_reg;

    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign out_valid = out_valid_reg;

    pix_t in_pix;
    assign in_pix = '{fy: fg_luma, fcr: fg_cr, fcb: fg_cb,
                      by: bg_luma, bcr: bg_cr, bcb: bg_cb};

    // Stage 1: absolute chroma differences from the key.
    logic             s1_vld_reg;
    pix_t             s1_pix_reg;
    logic [PIX_W-1:0] s1_dcr_reg;
    logic [PIX_W-1:0] s1_dcb_reg;
    logic [PIX_W-1:0] s1_dcr_next;
    logic [PIX_W-1:0] s1_dcb_next;

    always_comb
    begin
        s1_dcr_next = (fg_cr > key_cr_reg) ? fg_cr - key_cr_reg : key_cr_reg - fg_cr;
        s1_dcb_next = (fg_cb > key_cb_reg) ? fg_cb - key_cb_reg : key_cb_reg - fg_cb;
    end

    // Stage 2: squared magnitude scaled by 256 for a Q.4 root.
    logic            s2_vld_reg;
    pix_t            s2_pix_reg;
    logic [SQ_W-1:0] s2_v_reg;
    logic [SQ_W-1:0] s2_v_next;

    always_comb
    begin
        s2_v_next = (SQ_W'(s1_dcr_reg) * SQ_W'(s1_dcr_reg)
                   + SQ_W'(s1_dcb_reg) * SQ_W'(s1_dcb_reg)) << 8;
    end

    // Square root pipeline.
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    pix_t              sq_pix;

    ckb_isqrt_pipe u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s2_vld_reg),
        .in_v     (s2_v_reg),
        .in_pix   (s2_pix_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_pix  (sq_pix)
    );

    // Threshold stage: pick full background, full foreground or the ramp.
    logic              th_vld_reg;
    pix_t              th_pix_reg;
    mode_t             th_mode_reg;
    logic [REM_W-1:0]  th_rem_reg;
    logic [ROOT_W-1:0] th_den_reg;
    mode_t             th_mode_next;
    logic [ROOT_W-1:0] lo;
    logic [ROOT_W-1:0] hi;

    always_comb
    begin
        lo = {inner_reg, 4'b0000};
        hi = {outer_reg, 4'b0000};
        priority if (sq_root <= lo)
        begin
            th_mode_next = MODE_BG;
        end
        else if (sq_root >= hi)
        begin
            th_mode_next = MODE_FG;
        end
        else
        begin
            th_mode_next = MODE_RAMP;
        end
    end

    // Division stages: foreground weight = (dist - lo) * 256 / (hi - lo).
    logic              dv_vld_reg  [DIV_STAGES];
    pix_t              dv_pix_reg  [DIV_STAGES];
    mode_t             dv_mode_reg [DIV_STAGES];
    dv_t               dv_st_reg   [DIV_STAGES];
    logic [ROOT_W-1:0] dv_den_reg  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        logic              vld_in;
        pix_t              pix_in;
        mode_t             mode_in;
        dv_t               st_in;
        dv_t               st_next;
        logic [ROOT_W-1:0] den_in;

        if (s == 0) begin : g_first
            assign vld_in  = th_vld_reg;
            assign pix_in  = th_pix_reg;
            assign mode_in = th_mode_reg;
            assign st_in   = '{rem: th_rem_reg, q: '0};
            assign den_in  = th_den_reg;
        end else begin : g_rest
            assign vld_in  = dv_vld_reg[s-1];
            assign pix_in  = dv_pix_reg[s-1];
            assign mode_in = dv_mode_reg[s-1];
            assign st_in   = dv_st_reg[s-1];
            assign den_in  = dv_den_reg[s-1];
        end

        always_comb
        begin
            st_next = st_in;
            for (int j = 0; j < DIV_PER_STG; j++)
            begin
                st_next = div_step(st_next, den_in);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_pix_reg[s]  <= pix_in;
                dv_mode_reg[s] <= mode_in;
                dv_st_reg[s]   <= st_next;
                dv_den_reg[s]  <= den_in;
            end
        end
    end

    // Multiply stage: both weighted terms for each channel.
    logic               mu_vld_reg;
    logic [PROD_W-1:0]  mu_fy_reg, mu_by_reg, mu_fcr_reg, mu_bcr_reg, mu_fcb_reg, mu_bcb_reg;
    logic [ALPHA_W-1:0] alpha;
    logic [ALPHA_W-1:0] fgw;
    pix_t               dv_pix;

    assign dv_pix = dv_pix_reg[DIV_STAGES-1];

    always_comb
    begin
        unique case (dv_mode_reg[DIV_STAGES-1])
            MODE_BG:   alpha = ALPHA_W'(256);
            MODE_FG:   alpha = '0;
            MODE_RAMP: alpha = ALPHA_W'(256) - ALPHA_W'(dv_st_reg[DIV_STAGES-1].q);
            default:   alpha = '0;
        endcase
        fgw = ALPHA_W'(256) - alpha;
    end

    // Output stage: sum, drop the eight fraction bits.
    logic [PROD_W:0] sum_y, sum_cr, sum_cb;

    always_comb
    begin
        sum_y  = {1'b0, mu_fy_reg}  + {1'b0, mu_by_reg};
        sum_cr = {1'b0, mu_fcr_reg} + {1'b0, mu_bcr_reg};
        sum_cb = {1'b0, mu_fcb_reg} + {1'b0, mu_bcb_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            th_vld_reg    <= 1'b0;
            mu_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            th_vld_reg    <= sq_vld;
            mu_vld_reg    <= dv_vld_reg[DIV_STAGES-1];
            out_valid_reg <= mu_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= in_pix;
            s1_dcr_reg  <= s1_dcr_next;
            s1_dcb_reg  <= s1_dcb_next;
            s2_pix_reg  <= s1_pix_reg;
            s2_v_reg    <= s2_v_next;
            th_pix_reg  <= sq_pix;
            th_mode_reg <= th_mode_next;
            th_rem_reg  <= REM_W'(sq_root - lo);
            th_den_reg  <= hi - lo;
            mu_fy_reg   <= PROD_W'(fgw)   * PROD_W'(dv_pix.fy);
            mu_by_reg   <= PROD_W'(alpha) * PROD_W'(dv_pix.by);
            mu_fcr_reg  <= PROD_W'(fgw)   * PROD_W'(dv_pix.fcr);
            mu_bcr_reg  <= PROD_W'(alpha) * PROD_W'(dv_pix.bcr);
            mu_fcb_reg  <= PROD_W'(fgw)   * PROD_W'(dv_pix.fcb);
            mu_bcb_reg  <= PROD_W'(alpha) * PROD_W'(dv_pix.bcb);
            out_luma    <= sum_y[15:8];
            out_cr      <= sum_cr[15:8];
            out_cb      <= sum_cb[15:8];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ckb_checker.sv @@
// Port-level checker for the chroma key soft blend block, bound to the top.
// Depends on ckb_pkg and chroma_key_soft_blend_defines.svh.
`default_nettype none
`include "chroma_key_soft_blend_defines.svh"
module ckb_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic [ckb_pkg::PIX_W-1:0] out_luma,
    input wire logic [ckb_pkg::PIX_W-1:0] out_cr,
    input wire logic [ckb_pkg::PIX_W-1:0] out_cb
);
    import ckb_pkg::*;

    // A held result stays offered.
    `CKB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // A held result keeps its payload.
    `CKB_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(out_luma) && $stable(out_cr) && $stable(out_cb))
    // A held result freezes the pipeline, so the input side must stall too.
    `CKB_ASSERT_NOW(a_in_backpressure, out_valid && out_stall, in_stall)
    // With no result waiting the block always takes new pixels.
    `CKB_ASSERT_NOW(a_in_free, !out_valid, !in_stall)

endmodule

bind chroma_key_soft_blend ckb_checker u_ckb_checker (.*);
`default_nettype wire
